### hw/rtl/semantic_layout_distance_top_assert.svh
// Assertion macros for the semantic layout distance block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SEMANTIC_LAYOUT_DISTANCE_TOP_ASSERT_SVH
`define SEMANTIC_LAYOUT_DISTANCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SLD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SLD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define SLD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/sld_pkg.sv
// Types and constants of the semantic layout distance block.
// No dependencies.
`timescale 1ns / 1ps
package sld_pkg;

    localparam int REL_POSITIONS = 9;
    localparam int NO_MATCH_DISTANCE = 256;
    localparam int DIST_ONES = 511;

    typedef struct packed {
        logic        func;
        logic [2:0]  color;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        last;
    } t_req;

    typedef struct packed {
        logic [8:0] distance;
        logic       no_match;
    } t_rsp;

    // Class codes: 0 less, 1 equal, 2 greater.
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    function automatic logic [3:0] rel_pos(input logic [1:0] cx, input logic [1:0] cy);
        logic [3:0] r;
        r = 4'd0;
        case ({cx, cy})
            {CMP_LT, CMP_LT}: r = 4'd2;
            {CMP_LT, CMP_EQ}: r = 4'd1;
            {CMP_LT, CMP_GT}: r = 4'd8;
            {CMP_EQ, CMP_LT}: r = 4'd3;
            {CMP_EQ, CMP_EQ}: r = 4'd0;
            {CMP_EQ, CMP_GT}: r = 4'd7;
            {CMP_GT, CMP_LT}: r = 4'd4;
            {CMP_GT, CMP_EQ}: r = 4'd5;
            {CMP_GT, CMP_GT}: r = 4'd6;
            default:          r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/sld_bin.sv
// Histogram bin of a superpixel about a base: colour times nine plus relative position.
// Depends on sld_pkg.
`timescale 1ns / 1ps
module sld_bin #(
    parameter int COLOR_CLASSES = 8,
    parameter int COORD_BITS    = 16
) (
    input  logic [$clog2(COLOR_CLASSES)-1:0]                         i_color,
    input  logic [COORD_BITS-1:0]                                    i_x,
    input  logic [COORD_BITS-1:0]                                    i_y,
    input  logic [COORD_BITS-1:0]                                    i_base_x,
    input  logic [COORD_BITS-1:0]                                    i_base_y,
    output logic [$clog2(COLOR_CLASSES*sld_pkg::REL_POSITIONS)-1:0]  o_bin
);
    import sld_pkg::*;

    localparam int KW = $clog2(COLOR_CLASSES * REL_POSITIONS);

    logic [1:0] cx;
    logic [1:0] cy;
    logic [3:0] rel;

    always_comb begin
        cx  = (i_x < i_base_x) ? CMP_LT : ((i_x == i_base_x) ? CMP_EQ : CMP_GT);
        cy  = (i_y < i_base_y) ? CMP_LT : ((i_y == i_base_y) ? CMP_EQ : CMP_GT);
        rel = rel_pos(cx, cy);
        o_bin = KW'(KW'(i_color) * KW'(REL_POSITIONS)) + KW'(rel);
    end

endmodule

### hw/rtl/semantic_layout_distance_top.sv
// Semantic layout distance: reference superpixels (func 0) build a colour by relative-position
// histogram about their first element; test superpixels (func 1) are stored, and the test item
// marked last starts the search. After the last test item the block checks each of the N
// stored superpixels in turn, and for each one whose colour matches the reference base it
// rebuilds the test histogram at one superpixel per cycle and then sums the L1 difference at
// one bin per cycle. The superpixel store has a single read port. The result sits in an
// output register; a new item may be taken while it waits.
// Depends on sld_pkg, sld_bin and semantic_layout_distance_top_assert.svh.
`timescale 1ns / 1ps
`include "semantic_layout_distance_top_assert.svh"
module semantic_layout_distance_top #(
    parameter int MAX_SUPERPIXELS = 128,
    parameter int COLOR_CLASSES   = 8,
    parameter int COORD_BITS      = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sld_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output sld_pkg::t_rsp o_rsp
);
    import sld_pkg::*;

    localparam int CW        = $clog2(COLOR_CLASSES);
    localparam int CB        = COORD_BITS;
    localparam int HIST_BINS = COLOR_CLASSES * REL_POSITIONS;
    localparam int KW        = $clog2(HIST_BINS);
    localparam int KCW       = $clog2(HIST_BINS + 1);
    localparam int AW        = $clog2(2 * HIST_BINS);
    localparam int SW        = $clog2(MAX_SUPERPIXELS);
    localparam int CNTW      = $clog2(MAX_SUPERPIXELS + 1);
    localparam int SPW       = CW + 2 * CB;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_REFRD = 8'b0000_0010,
        ST_REFWR = 8'b0000_0100,
        ST_JRD   = 8'b0000_1000,
        ST_JCHK  = 8'b0001_0000,
        ST_HRUN  = 8'b0010_0000,
        ST_L1    = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // control
    logic [CNTW-1:0]      r_ref_count;
    logic                 r_ref_closed;
    logic                 r_ref_valid;
    logic [CNTW-1:0]      r_test_count;
    logic [CNTW-1:0]      r_j;
    logic [CNTW-1:0]      r_i;
    logic [KCW-1:0]       r_k;
    logic                 r_p1_v;
    logic                 r_p2_v;
    logic                 r_l_v;
    logic                 r_wr_v;
    logic                 r_matched;
    logic                 r_out_valid;
    logic [HIST_BINS-1:0] r_ref_vld;
    logic [HIST_BINS-1:0] r_tst_vld;

    // payload
    logic [CW-1:0]        r_item_c;
    logic [CB-1:0]        r_item_x, r_item_y;
    logic [CW-1:0]        r_ref_c;
    logic [CB-1:0]        r_ref_x, r_ref_y;
    logic [CB-1:0]        r_b_x, r_b_y;
    logic [KW-1:0]        r_p2_k;
    logic                 r_p2_tst;
    logic [AW-1:0]        r_wr_addr;
    logic [7:0]           r_wr_val;
    logic [KW-1:0]        r_l_k;
    logic [8:0]           r_acc;
    logic [8:0]           r_best;
    t_rsp                 r_out;

    // memories
    logic [SPW-1:0]       store_mem [MAX_SUPERPIXELS];
    logic [SPW-1:0]       s_rd;
    logic [7:0]           hist_mem [2 * HIST_BINS];
    logic [7:0]           h_rd_a, h_rd_b;

    logic                 req_fire;
    logic [CW-1:0]        in_c;
    logic [CB-1:0]        in_x, in_y;
    logic                 ref_new;
    logic [CNTW-1:0]      ref_eff;
    logic [CNTW-1:0]      j_next;
    logic                 h_issue, l_issue;
    logic [CW-1:0]        s_c;
    logic [CB-1:0]        s_x, s_y;
    logic [CW-1:0]        bin_c;
    logic [CB-1:0]        bin_x, bin_y, bin_bx, bin_by;
    logic [KW-1:0]        bin;
    logic [SW-1:0]        s_ra;
    logic                 s_we;
    logic [AW-1:0]        h_ra_a, h_ra_b;
    logic [AW-1:0]        p2_addr;
    logic                 h_we;
    logic                 p2_vld;
    logic [7:0]           s2_old, s2_new;
    logic [7:0]           l_ref, l_tst, l_diff;
    logic [9:0]           l_sum;
    logic [8:0]           acc_next;
    logic                 out_free;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
    assign out_free    = !r_out_valid || i_rsp_ready;

    always_comb begin
        in_c = (int'(i_req.color) >= COLOR_CLASSES) ? CW'(COLOR_CLASSES - 1) : CW'(i_req.color);
        in_x = CB'(i_req.pos_x);
        in_y = CB'(i_req.pos_y);
    end

    assign ref_new = r_ref_closed || !r_ref_valid;
    assign ref_eff = ref_new ? '0 : r_ref_count;
    assign j_next  = r_j + CNTW'(1);
    assign h_issue = (r_i < r_test_count);
    assign l_issue = (r_k < KCW'(HIST_BINS));

    assign s_c = s_rd[SPW-1 -: CW];
    assign s_x = s_rd[2*CB-1 -: CB];
    assign s_y = s_rd[CB-1:0];

    // One bin unit: reference item while reading for it, stored superpixel otherwise
    always_comb begin
        if (r_state == ST_REFRD) begin
            bin_c  = r_item_c;
            bin_x  = r_item_x;
            bin_y  = r_item_y;
            bin_bx = r_ref_x;
            bin_by = r_ref_y;
        end else begin
            bin_c  = s_c;
            bin_x  = s_x;
            bin_y  = s_y;
            bin_bx = r_b_x;
            bin_by = r_b_y;
        end
    end

    sld_bin #(
        .COLOR_CLASSES (COLOR_CLASSES),
        .COORD_BITS    (COORD_BITS)
    ) u_bin (
        .i_color  (bin_c),
        .i_x      (bin_x),
        .i_y      (bin_y),
        .i_base_x (bin_bx),
        .i_base_y (bin_by),
        .o_bin    (bin)
    );

    always_comb begin
        s_ra = (r_state == ST_JRD) ? r_j[SW-1:0] : r_i[SW-1:0];
        s_we = req_fire && i_req.func && (r_test_count < CNTW'(MAX_SUPERPIXELS));
        case (r_state)
            ST_REFRD: h_ra_a = AW'(bin);
            ST_HRUN:  h_ra_a = AW'(HIST_BINS) + AW'(bin);
            default:  h_ra_a = AW'(r_k[KW-1:0]);
        endcase
        h_ra_b  = AW'(HIST_BINS) + AW'(r_k[KW-1:0]);
        p2_addr = r_p2_tst ? (AW'(HIST_BINS) + AW'(r_p2_k)) : AW'(r_p2_k);
        h_we    = (r_state == ST_REFWR) || ((r_state == ST_HRUN) && r_p2_v);
        p2_vld  = r_p2_tst ? r_tst_vld[r_p2_k] : r_ref_vld[r_p2_k];
        // forward the write of the previous cycle, the memory still returns the old count
        if (r_wr_v && (r_wr_addr == p2_addr)) begin
            s2_old = r_wr_val;
        end else begin
            s2_old = p2_vld ? h_rd_a : 8'd0;
        end
        s2_new = (s2_old == 8'hFF) ? s2_old : (s2_old + 8'd1);
        l_ref  = r_ref_vld[r_l_k] ? h_rd_a : 8'd0;
        l_tst  = r_tst_vld[r_l_k] ? h_rd_b : 8'd0;
        l_diff = (l_tst > l_ref) ? (l_tst - l_ref) : (l_ref - l_tst);
        l_sum  = {1'b0, r_acc} + 10'(l_diff);
        acc_next = (l_sum > 10'(DIST_ONES)) ? 9'(DIST_ONES) : l_sum[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            store_mem[r_test_count[SW-1:0]] <= {in_c, in_x, in_y};
        end
        s_rd <= store_mem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hist_mem[p2_addr] <= s2_new;
        end
        h_rd_a <= hist_mem[h_ra_a];
        h_rd_b <= hist_mem[h_ra_b];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (!i_req.func) begin
                        if (ref_eff < CNTW'(MAX_SUPERPIXELS)) begin
                            n_state = ST_REFRD;
                        end
                    end else if (i_req.last) begin
                        n_state = ST_JRD;
                    end
                end
            end
            ST_REFRD: n_state = ST_REFWR;
            ST_REFWR: n_state = ST_IDLE;
            ST_JRD:   n_state = ST_JCHK;
            ST_JCHK: begin
                if (s_c == r_ref_c) begin
                    n_state = ST_HRUN;
                end else begin
                    n_state = (j_next >= r_test_count) ? ST_FIN : ST_JRD;
                end
            end
            ST_HRUN: begin
                if (!h_issue && !r_p1_v && !r_p2_v) begin
                    n_state = ST_L1;
                end
            end
            ST_L1: begin
                if (!l_issue && !r_l_v) begin
                    n_state = (j_next >= r_test_count) ? ST_FIN : ST_JRD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p2_k    <= bin;
        r_p2_tst  <= (r_state != ST_REFRD);
        r_wr_addr <= p2_addr;
        r_wr_val  <= s2_new;
        r_l_k     <= r_k[KW-1:0];
        if (req_fire) begin
            r_item_c <= in_c;
            r_item_x <= in_x;
            r_item_y <= in_y;
        end
        if ((r_state == ST_JCHK) && (s_c == r_ref_c)) begin
            r_b_x <= s_x;
            r_b_y <= s_y;
        end
        if (r_state == ST_HRUN) begin
            r_acc <= '0;
        end else if (r_l_v) begin
            r_acc <= acc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ref_count  <= '0;
            r_ref_closed <= 1'b0;
            r_ref_valid  <= 1'b0;
            r_test_count <= '0;
            r_j          <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_l_v        <= 1'b0;
            r_wr_v       <= 1'b0;
            r_matched    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ref_vld    <= '0;
            r_tst_vld    <= '0;
            r_ref_c      <= '0;
            r_ref_x      <= '0;
            r_ref_y      <= '0;
            r_best       <= 9'(DIST_ONES);
            r_out        <= '0;
        end else begin
            r_state <= n_state;
            r_wr_v  <= h_we;
            r_p1_v  <= (r_state == ST_HRUN) && h_issue;
            r_p2_v  <= r_p1_v;
            r_l_v   <= (r_state == ST_L1) && l_issue;

            if (h_we) begin
                if (r_p2_tst) begin
                    r_tst_vld[r_p2_k] <= 1'b1;
                end else begin
                    r_ref_vld[r_p2_k] <= 1'b1;
                end
            end

            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (req_fire && !i_req.func) begin
                        // a reference after a closed load starts a fresh histogram
                        if (ref_new) begin
                            r_ref_vld    <= '0;
                            r_ref_valid  <= 1'b1;
                        end
                        if (ref_eff < CNTW'(MAX_SUPERPIXELS)) begin
                            if (ref_eff == '0) begin
                                r_ref_c <= in_c;
                                r_ref_x <= in_x;
                                r_ref_y <= in_y;
                            end
                            r_ref_count <= ref_eff + CNTW'(1);
                        end else begin
                            r_ref_count <= ref_eff;
                        end
                        r_ref_closed <= i_req.last;
                    end else if (req_fire) begin
                        if (s_we) begin
                            r_test_count <= r_test_count + CNTW'(1);
                        end
                        if (i_req.last) begin
                            r_j       <= '0;
                            r_matched <= 1'b0;
                            r_best    <= 9'(DIST_ONES);
                        end
                    end
                end
                ST_JCHK: begin
                    if (s_c == r_ref_c) begin
                        r_tst_vld <= '0;
                        r_i       <= '0;
                    end else begin
                        r_j <= j_next;
                    end
                end
                ST_HRUN: begin
                    if (h_issue) begin
                        r_i <= r_i + CNTW'(1);
                    end
                    r_k <= '0;
                end
                ST_L1: begin
                    if (l_issue) begin
                        r_k <= r_k + KCW'(1);
                    end
                    if (!l_issue && !r_l_v) begin
                        if (!r_matched || (r_acc < r_best)) begin
                            r_best <= r_acc;
                        end
                        r_matched <= 1'b1;
                        r_j       <= j_next;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out.distance <= r_matched ? r_best : 9'(NO_MATCH_DISTANCE);
                        r_out.no_match <= !r_matched;
                        r_test_count   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `SLD_ASSERT_ALWAYS(a_test_count_bound, i_clk, i_rst_n, r_test_count <= CNTW'(MAX_SUPERPIXELS), "test count beyond store depth")
    `SLD_ASSERT_IMPLY(a_no_match_dist, i_clk, i_rst_n, o_rsp_valid && o_rsp.no_match, o_rsp.distance == 9'(NO_MATCH_DISTANCE), "no_match without its distance")
    `SLD_ASSERT_IMPLY(a_l1_drained, i_clk, i_rst_n, r_state == ST_L1, !r_p1_v && !r_p2_v, "histogram build still in flight during L1")
    `SLD_ASSERT_NEXT(a_last_starts_eval, i_clk, i_rst_n, req_fire && i_req.func && i_req.last, r_state == ST_JRD, "last test request did not start evaluation")

endmodule
